/* design/opmu_pkg.sv */
// Package for the outer-product matrix unit: field widths, command and status codes,
// sequencer states and parameter defaults. No dependencies.
`default_nettype none
package opmu_pkg;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned MSEL_W     = 5;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PROD_W     = 16;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  localparam int unsigned MAX_SIDE_DEF     = 64;
  localparam int unsigned NUM_MATRICES_DEF = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_STAGE = 3'd0,
    CMD_MAC   = 3'd1,
    CMD_BCAST = 3'd2,
    CMD_READ  = 3'd3,
    CMD_WRITE = 3'd4
  } opmu_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_MATRIX = 2'd1,
    STS_INDEX  = 2'd2,
    STS_LENGTH = 2'd3
  } opmu_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAC,
    S_BCAST,
    S_DONE
  } opmu_state_e;

endpackage
`default_nettype wire

/* design/opmu_in_if.sv */
// Input channel of the outer-product matrix unit: one element beat per handshake.
// Depends on opmu_pkg for field widths.
`default_nettype none
interface opmu_in_if;
  logic                                valid;
  logic                                ready;
  logic        [opmu_pkg::CMD_W-1:0]   cmd;
  logic        [opmu_pkg::MSEL_W-1:0]  matrix_sel;
  logic        [opmu_pkg::ROW_W-1:0]   row_index;
  logic        [opmu_pkg::COL_W-1:0]   col_index;
  logic signed [opmu_pkg::DATA_W-1:0]  elem_value;
  logic        [opmu_pkg::DIM_W-1:0]   vec_len;

  modport source (
    output valid, cmd, matrix_sel, row_index, col_index, elem_value, vec_len,
    input  ready
  );
  modport sink (
    input  valid, cmd, matrix_sel, row_index, col_index, elem_value, vec_len,
    output ready
  );
endinterface
`default_nettype wire

/* design/opmu_out_if.sv */
// Result channel of the outer-product matrix unit: one result beat per input beat.
// Depends on opmu_pkg for field widths.
`default_nettype none
interface opmu_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [opmu_pkg::STATUS_W-1:0] status;
  logic signed [opmu_pkg::DATA_W-1:0]   read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface
`default_nettype wire

/* design/outer_product_matrix_unit.sv */
// Top level of the outer-product matrix unit: accumulator memory, B operand store,
// sequencer and result register. Depends on opmu_pkg, opmu_in_if and opmu_out_if.

// After reset the unit clears all 2 ** (matrix-select bits + 2 * index bits) accumulator
// words, 16384 with the defaults, during which no beat is accepted; configuration writes
// are taken at any time. Every input beat gives exactly one result beat. Stage, write, read,
// unused-command and flagged beats, and mac with vec_len zero, go straight from accept to the
// result state, broadcast first walks side rows and any other mac walks vec_len columns: the
// accumulator memory has one read port and one write port, each used once per cycle, so mac
// walks one column per cycle through one 8x8 multiplier and 32-bit adder, and broadcast
// one row per cycle. A result waiting in the output register does not stop the next beat
// from being accepted; the sequencer then holds in S_DONE until the output register is free.
`default_nettype none
module outer_product_matrix_unit #(
  parameter int unsigned MAX_SIDE     = opmu_pkg::MAX_SIDE_DEF,
  parameter int unsigned NUM_MATRICES = opmu_pkg::NUM_MATRICES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [opmu_pkg::DIM_W-1:0]  cfg_wdata_i,
  opmu_in_if.sink                          in_i,
  opmu_out_if.source                       out_o
);
  import opmu_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_SIDE);
  localparam int unsigned MAT_W  = (NUM_MATRICES > 1) ? $clog2(NUM_MATRICES) : 1;
  localparam int unsigned ADDR_W = MAT_W + 2 * IDX_W;
  localparam int unsigned DEPTH  = 2 ** ADDR_W;
  localparam int unsigned BDEPTH = 2 ** IDX_W;
  localparam logic [DIM_W-1:0]  SIDE_MAX = DIM_W'(MAX_SIDE);
  localparam logic [MSEL_W-1:0] NUM_MAT  = MSEL_W'(NUM_MATRICES);

  opmu_state_e state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [DIM_W-1:0]  cnt_q, cnt_d;
  logic [DIM_W-1:0]  dim_q, side;

  logic [MAT_W-1:0]        mat_q;
  logic [IDX_W-1:0]        row_q, col_q;
  logic [DATA_W-1:0]       val_q;
  logic [DIM_W-1:0]        vl_q;
  logic signed [BYTE_W-1:0] a_q;
  logic                    load_op;

  opmu_status_e chk_status;
  opmu_status_e res_status_q, res_status_d;
  logic         res_rd_q, res_rd_d;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic              m_we, m_re;
  logic [ADDR_W-1:0] m_waddr, m_raddr, acc_addr;
  logic [DATA_W-1:0] m_wdata, m_rdata_q;

  logic [BYTE_W-1:0] b_mem_q [BDEPTH];
  logic              b_we, b_re;
  logic [IDX_W-1:0]  b_waddr, b_raddr;
  logic [BYTE_W-1:0] b_wdata;
  logic signed [BYTE_W-1:0] b_rdata_q;

  logic              wb_vld_q, wb_vld_d;
  logic [ADDR_W-1:0] wb_addr_q;
  logic signed [PROD_W-1:0] mac_prod;
  logic [DATA_W-1:0] mac_sum;

  logic                    in_rdy, out_load;
  logic                    out_vld_q;
  logic [STATUS_W-1:0]     out_status_q;
  logic [DATA_W-1:0]       out_value_q;

  assign side     = (dim_q > SIDE_MAX) ? SIDE_MAX : dim_q;
  assign acc_addr = {in_i.matrix_sel[MAT_W-1:0], in_i.row_index[IDX_W-1:0],
                     in_i.col_index[IDX_W-1:0]};
  assign mac_prod = a_q * b_rdata_q;
  assign mac_sum  = m_rdata_q + {{(DATA_W-PROD_W){mac_prod[PROD_W-1]}}, mac_prod};

  always_comb begin
    chk_status = STS_OK;
    unique case (opmu_cmd_e'(in_i.cmd))
      CMD_STAGE: begin
        if ({1'b0, in_i.col_index} >= side) chk_status = STS_INDEX;
      end
      CMD_MAC: begin
        priority if (in_i.matrix_sel >= NUM_MAT) chk_status = STS_MATRIX;
        else if (in_i.vec_len > side) chk_status = STS_LENGTH;
        else if (in_i.row_index >= {1'b0, side}) chk_status = STS_INDEX;
        else chk_status = STS_OK;
      end
      CMD_BCAST: begin
        priority if (in_i.matrix_sel >= NUM_MAT) chk_status = STS_MATRIX;
        else if ({1'b0, in_i.col_index} >= side) chk_status = STS_INDEX;
        else chk_status = STS_OK;
      end
      CMD_READ, CMD_WRITE: begin
        priority if (in_i.matrix_sel >= NUM_MAT) chk_status = STS_MATRIX;
        else if (in_i.row_index >= {1'b0, side} || {1'b0, in_i.col_index} >= side)
          chk_status = STS_INDEX;
        else chk_status = STS_OK;
      end
      default: chk_status = STS_OK;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q + ADDR_W'(1);
    cnt_d        = cnt_q;
    m_we         = wb_vld_q;
    m_waddr      = wb_addr_q;
    m_wdata      = mac_sum;
    m_re         = 1'b0;
    m_raddr      = {mat_q, row_q, cnt_q[IDX_W-1:0]};
    b_we         = 1'b0;
    b_waddr      = in_i.col_index[IDX_W-1:0];
    b_wdata      = in_i.elem_value[BYTE_W-1:0];
    b_re         = 1'b0;
    b_raddr      = cnt_q[IDX_W-1:0];
    in_rdy       = 1'b0;
    load_op      = 1'b0;
    res_status_d = res_status_q;
    res_rd_d     = res_rd_q;
    wb_vld_d     = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
        m_wdata = '0;
        b_we    = 1'b1;
        b_waddr = clr_q[IDX_W-1:0];
        b_wdata = '0;
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_i.valid) begin
          load_op      = 1'b1;
          cnt_d        = '0;
          res_status_d = chk_status;
          res_rd_d     = 1'b0;
          state_d      = S_DONE;
          if (chk_status == STS_OK) begin
            unique case (opmu_cmd_e'(in_i.cmd))
              CMD_STAGE: b_we = 1'b1;
              CMD_MAC: begin
                if (in_i.vec_len != '0) state_d = S_MAC;
              end
              CMD_BCAST: state_d = S_BCAST;
              CMD_READ: begin
                m_re     = 1'b1;
                m_raddr  = acc_addr;
                res_rd_d = 1'b1;
              end
              CMD_WRITE: begin
                m_we    = 1'b1;
                m_waddr = acc_addr;
                m_wdata = in_i.elem_value;
              end
              default: ;
            endcase
          end
        end
      end
      S_MAC: begin
        if (cnt_q < vl_q) begin
          m_re     = 1'b1;
          b_re     = 1'b1;
          wb_vld_d = 1'b1;
          cnt_d    = cnt_q + DIM_W'(1);
        end else begin
          state_d = S_DONE;
        end
      end
      S_BCAST: begin
        m_we    = 1'b1;
        m_waddr = {mat_q, cnt_q[IDX_W-1:0], col_q};
        m_wdata = val_q;
        cnt_d   = cnt_q + DIM_W'(1);
        if (cnt_q == side - DIM_W'(1)) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      cnt_q        <= '0;
      dim_q        <= DIM_RESET;
      res_status_q <= STS_OK;
      res_rd_q     <= 1'b0;
      wb_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      cnt_q        <= cnt_d;
      res_status_q <= res_status_d;
      res_rd_q     <= res_rd_d;
      wb_vld_q     <= wb_vld_d;
      if (cfg_we_i) dim_q <= cfg_wdata_i;
      if (out_load) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_op) begin
      mat_q <= in_i.matrix_sel[MAT_W-1:0];
      row_q <= in_i.row_index[IDX_W-1:0];
      col_q <= in_i.col_index[IDX_W-1:0];
      val_q <= in_i.elem_value;
      vl_q  <= in_i.vec_len;
      a_q   <= in_i.elem_value[BYTE_W-1:0];
    end
    wb_addr_q <= m_raddr;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_rd_q ? m_rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_we) mem_q[m_waddr] <= m_wdata;
    if (m_re) m_rdata_q <= mem_q[m_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) b_mem_q[b_waddr] <= b_wdata;
    if (b_re) b_rdata_q <= b_mem_q[b_raddr];
  end

  assign in_i.ready       = in_rdy;
  assign out_o.valid      = out_vld_q;
  assign out_o.status     = out_status_q;
  assign out_o.read_value = out_value_q;

  a_wb_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_vld_q |-> state_q == S_MAC)
    else $error("mac write-back outside mac walk");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_CLEAR |=> state_q != S_CLEAR)
    else $error("clearing pass re-entered");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_status_q != STS_OK |-> out_value_q == '0)
    else $error("flagged beat carries read data");

  a_mac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAC |-> cnt_q <= vl_q)
    else $error("mac column counter past vec_len");

endmodule
`default_nettype wire
